// File: rtl/gjfd_pkg.sv
// shared types and constants for the grid jacobian unit
package gjfd_pkg;

  localparam int unsigned DefMaxX = 16;
  localparam int unsigned DefMaxY = 16;
  localparam int unsigned DefMaxZ = 16;

  localparam int unsigned PosW   = 4;
  localparam int unsigned CompW  = 24;
  localparam int unsigned DerW   = 32;
  localparam int unsigned SizeW  = 5;
  localparam int unsigned SpaceW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned VecW   = 3 * CompW;

  localparam logic [CfgIdxW-1:0] RegSizeX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSizeY  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSizeZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpaceX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpaceY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSpaceZ = 3'd5;

  localparam logic CmdStore = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [PosW-1:0]         pos_x;
    logic [PosW-1:0]         pos_y;
    logic [PosW-1:0]         pos_z;
    logic signed [CompW-1:0] comp_x;
    logic signed [CompW-1:0] comp_y;
    logic signed [CompW-1:0] comp_z;
  } req_t;

  typedef struct packed {
    logic signed [DerW-1:0] dx_vx;
    logic signed [DerW-1:0] dx_vy;
    logic signed [DerW-1:0] dx_vz;
    logic signed [DerW-1:0] dy_vx;
    logic signed [DerW-1:0] dy_vy;
    logic signed [DerW-1:0] dy_vz;
    logic signed [DerW-1:0] dz_vx;
    logic signed [DerW-1:0] dz_vy;
    logic signed [DerW-1:0] dz_vz;
    logic                   bad_index;
  } rsp_t;

  // command from sequencer to the derivative datapath
  typedef struct packed {
    logic        load_hi;
    logic        load_lo;
    logic        zero;
    logic        half;
    logic [1:0]  axis;
    logic        store;
  } dp_ctl_t;

endpackage

// File: rtl/gjfd_if.sv
// valid/ready channel carrying one payload type
interface gjfd_if #(parameter type payload_t = logic) (input logic clk_i);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/grid_jacobian_finite_difference_unit.sv
// Grid Jacobian unit. Channel in_if carries req_t transactions: a store (cmd 0)
// writes one vector into the grid memory, a query (cmd 1) returns one rsp_t on
// out_if with the nine Jacobian entries and bad_index. Stores give no result.
// Configuration is a write port (cfg_we_i, cfg_idx_i, cfg_data_i) for the
// three sizes and three reciprocal spacings; write only while idle.
// Timing: a store is written at its accepting edge and the next transaction can
// follow in the very next cycle. A query walks the three axes, each in turn through
// high read, low read, capture with multiply and result, reading both neighbours
// one after the other from the single-port grid memory over its one port. An
// out-of-grid query answers in the cycle after acceptance.
// The result sits in an output register; a new transaction is taken in the cycle
// after it has been delivered, and a stalled receiver holds the block.
// Reset restores the register defaults; grid contents are undefined until
// written and a point must be stored before it is queried.
module grid_jacobian_finite_difference_unit #(
  parameter int unsigned MaxX = gjfd_pkg::DefMaxX,
  parameter int unsigned MaxY = gjfd_pkg::DefMaxY,
  parameter int unsigned MaxZ = gjfd_pkg::DefMaxZ
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gjfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gjfd_pkg::CfgDataW-1:0]  cfg_data_i,
  gjfd_if.sink                           in_if,
  gjfd_if.source                         out_if
);
  import gjfd_pkg::*;

  localparam int unsigned XW = $clog2(MaxX);
  localparam int unsigned YW = $clog2(MaxY);
  localparam int unsigned ZW = $clog2(MaxZ);
  localparam int unsigned AW = XW + YW + ZW;
  localparam int unsigned Depth = 1 << AW;

  localparam logic [3:0] StIdle = 4'd0, StRdHi = 4'd1, StRdLo = 4'd2, StCap = 4'd3,
                         StMul = 4'd4;

  logic [SizeW-1:0]  size_x_q, size_y_q, size_z_q;
  logic [SpaceW-1:0] inv_x_q, inv_y_q, inv_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SizeW'(16); size_y_q <= SizeW'(16); size_z_q <= SizeW'(16);
      inv_x_q <= SpaceW'(65536); inv_y_q <= SpaceW'(65536); inv_z_q <= SpaceW'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSizeX:  size_x_q <= cfg_data_i[SizeW-1:0];
        RegSizeY:  size_y_q <= cfg_data_i[SizeW-1:0];
        RegSizeZ:  size_z_q <= cfg_data_i[SizeW-1:0];
        RegSpaceX: inv_x_q <= cfg_data_i;
        RegSpaceY: inv_y_q <= cfg_data_i;
        RegSpaceZ: inv_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [8:0] eff(input logic [SizeW-1:0] s, input int unsigned m);
    if (s == '0) return 9'd1;
    if (32'(s) > m) return 9'(m);
    return 9'(s);
  endfunction

  logic [8:0] sx, sy, sz;
  assign sx = eff(size_x_q, MaxX);
  assign sy = eff(size_y_q, MaxY);
  assign sz = eff(size_z_q, MaxZ);

  req_t req;
  assign req = in_if.data;
  logic in_grid;
  assign in_grid = (9'(req.pos_x) < sx) && (9'(req.pos_y) < sy) && (9'(req.pos_z) < sz);

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [8:0] px_q, py_q, pz_q;
  logic [AW-1:0] addr_q;
  logic out_valid_q;
  rsp_t rsp_q;

  assign in_if.ready = (state_q == StIdle) && !out_valid_q;
  logic acc;
  assign acc = in_if.valid && in_if.ready;

  // per-axis selection
  logic [8:0] pos_a, size_a;
  logic [AW-1:0] stride_a;
  logic [SpaceW-1:0] inv_a;
  always_comb begin
    unique case (axis_q)
      2'd0: begin pos_a = px_q; size_a = sx; stride_a = AW'(1); inv_a = inv_x_q; end
      2'd1: begin pos_a = py_q; size_a = sy; stride_a = AW'(1 << XW); inv_a = inv_y_q; end
      default: begin
        pos_a = pz_q; size_a = sz; stride_a = AW'(1 << (XW + YW)); inv_a = inv_z_q;
      end
    endcase
  end

  dp_ctl_t ctl;
  assign ctl.zero    = size_a <= 9'd1;
  assign ctl.half    = !(pos_a == 9'd0) && !(pos_a == size_a - 9'd1);
  assign ctl.axis    = axis_q;
  assign ctl.load_hi = state_q == StRdLo;
  assign ctl.load_lo = state_q == StCap;
  assign ctl.store   = acc && req.cmd == CmdStore && in_grid;

  logic [AW-1:0] hi_addr, lo_addr, mem_addr;
  assign hi_addr = (pos_a == 9'd0 || ctl.half) ? addr_q + stride_a : addr_q;
  assign lo_addr = (pos_a == 9'd0) ? addr_q : addr_q - stride_a;

  logic [AW-1:0] req_addr;
  assign req_addr = {ZW'(req.pos_z), YW'(req.pos_y), XW'(req.pos_x)};

  always_comb begin
    priority case (state_q)
      StRdHi:  mem_addr = hi_addr;
      StRdLo:  mem_addr = lo_addr;
      default: mem_addr = req_addr;
    endcase
  end

  logic [VecW-1:0] rdata;
  gjfd_ram #(.Width(VecW), .Depth(Depth)) u_ram (
    .clk_i,
    .we_i   (ctl.store),
    .addr_i (mem_addr),
    .wdata_i({req.comp_x, req.comp_y, req.comp_z}),
    .rdata_o(rdata)
  );

  logic [VecW-1:0] hi_q, lo_q;
  logic [VecW-1:0] lo_v;
  assign lo_v = ctl.load_lo ? rdata : lo_q;
  always_ff @(posedge clk_i) begin
    if (ctl.load_hi) hi_q <= rdata;
    if (ctl.load_lo) lo_q <= rdata;
  end

  // low neighbour goes straight from the memory into the multipliers in the capture cycle
  logic zero_q;
  logic signed [DerW-1:0] r0, r1, r2;
  gjfd_scale u_s0 (.clk_i, .hi_i(hi_q[3*CompW-1:2*CompW]),
                   .lo_i(lo_v[3*CompW-1:2*CompW]), .inv_i(inv_a), .half_i(ctl.half),
                   .res_o(r0));
  gjfd_scale u_s1 (.clk_i, .hi_i(hi_q[2*CompW-1:CompW]), .lo_i(lo_v[2*CompW-1:CompW]),
                   .inv_i(inv_a), .half_i(ctl.half), .res_o(r1));
  gjfd_scale u_s2 (.clk_i, .hi_i(hi_q[CompW-1:0]), .lo_i(lo_v[CompW-1:0]),
                   .inv_i(inv_a), .half_i(ctl.half), .res_o(r2));

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      StIdle: if (acc && req.cmd == CmdQuery) state_d = in_grid ? StRdHi : StIdle;
      StRdHi: state_d = StRdLo;
      StRdLo: state_d = StCap;
      StCap:  state_d = StMul;
      StMul: begin
        if (axis_q == 2'd2) begin
          state_d = StIdle; axis_d = 2'd0;
        end else begin
          state_d = StRdHi; axis_d = axis_q + 2'd1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      axis_q <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q <= axis_d;
      if (out_if.valid && out_if.ready) out_valid_q <= 1'b0;
      else if ((acc && req.cmd == CmdQuery && !in_grid) ||
               (state_q == StMul && axis_q == 2'd2)) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      px_q <= 9'(req.pos_x); py_q <= 9'(req.pos_y); pz_q <= 9'(req.pos_z);
      addr_q <= req_addr;
      rsp_q <= '{bad_index: (req.cmd == CmdQuery && !in_grid), default: '0};
    end
    if (state_q == StCap) begin
      zero_q <= ctl.zero;
    end
    if (state_q == StMul) begin
      unique case (axis_q)
        2'd0: begin
          rsp_q.dx_vx <= zero_q ? '0 : r0; rsp_q.dx_vy <= zero_q ? '0 : r1;
          rsp_q.dx_vz <= zero_q ? '0 : r2;
        end
        2'd1: begin
          rsp_q.dy_vx <= zero_q ? '0 : r0; rsp_q.dy_vy <= zero_q ? '0 : r1;
          rsp_q.dy_vz <= zero_q ? '0 : r2;
        end
        default: begin
          rsp_q.dz_vx <= zero_q ? '0 : r0; rsp_q.dz_vy <= zero_q ? '0 : r1;
          rsp_q.dz_vz <= zero_q ? '0 : r2;
        end
      endcase
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = rsp_q;

  a_lo_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_lo |=> lo_q == $past(lo_v))
    else $error("low neighbour not captured");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_if.ready)
    else $error("accepted while busy");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(rsp_q))
    else $error("result dropped under stall");
  a_no_store_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.store |-> state_q == StIdle)
    else $error("store during query");
endmodule

// File: rtl/gjfd_ram.sv
// generic single-port ram with registered read
module gjfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/gjfd_scale.sv
// difference times reciprocal spacing, halved for a central difference, rounded and saturated, one component
module gjfd_scale (
  input  logic                             clk_i,
  input  logic signed [gjfd_pkg::CompW-1:0] hi_i,
  input  logic signed [gjfd_pkg::CompW-1:0] lo_i,
  input  logic [gjfd_pkg::SpaceW-1:0]       inv_i,
  input  logic                              half_i,
  output logic signed [gjfd_pkg::DerW-1:0]  res_o
);
  import gjfd_pkg::*;
  localparam int unsigned DiffW = CompW + 1;
  localparam int unsigned ProdW = DiffW + SpaceW + 1;

  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod_d, prod_q, rnd;
  logic half_q;
  logic signed [ProdW-1:0] shd;
  logic signed [DerW-1:0]  sat;

  assign diff   = DiffW'(hi_i) - DiffW'(lo_i);
  assign prod_d = ProdW'(diff) * $signed({1'b0, inv_i});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    half_q <= half_i;
  end

  // round to nearest, ties up: add half then floor shift
  assign rnd = half_q ? prod_q + ProdW'(65536) : prod_q + ProdW'(32768);
  assign shd = half_q ? (rnd >>> 17) : (rnd >>> 16);

  always_comb begin
    if (shd > ProdW'(64'sh7FFF_FFFF)) begin
      sat = 32'sh7FFF_FFFF;
    end else if (shd < -ProdW'(64'sh8000_0000)) begin
      sat = -32'sh8000_0000;
    end else begin
      sat = shd[DerW-1:0];
    end
  end

  assign res_o = sat;
endmodule

// File: tb/sv/tb_grid_jacobian_finite_difference_unit.sv
// testbench for the grid jacobian unit: stores, queries and predicted jacobians
`timescale 1ns / 100ps
module tb_grid_jacobian_finite_difference_unit;
  import gjfd_pkg::*;

  localparam int unsigned Cells = DefMaxX * DefMaxY * DefMaxZ;
  localparam longint CycleLimit = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  gjfd_if #(.payload_t(req_t)) req_ch (.clk_i(clk_i));
  gjfd_if #(.payload_t(rsp_t)) rsp_ch (.clk_i(clk_i));

  grid_jacobian_finite_difference_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(req_ch.sink), .out_if(rsp_ch.source)
  );

  // predictor state
  logic [SizeW-1:0] sz_reg [3];
  logic [SpaceW-1:0] inv_reg [3];
  logic signed [CompW-1:0] grid_mem [Cells][3];
  bit written [Cells];

  rsp_t jacobian_q[$];
  int err_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  longint cycle_cnt = 0;

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned eff_size(int idx);
    int unsigned r;
    r = 32'(sz_reg[idx]);
    if (r == 0) return 1;
    if (r > 16) return 16;
    return r;
  endfunction

  function automatic logic signed [DerW-1:0] scale_diff(longint diff, logic [SpaceW-1:0] inv,
                                                       int sh);
    longint t, q;
    t = diff * longint'({32'b0, inv}) + (longint'(1) << (sh - 1));
    q = t >>> sh;  // arithmetic shift floors, matching the rounding rule
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic bit inside_grid(req_t r);
    return r.pos_x < eff_size(0) && r.pos_y < eff_size(1) && r.pos_z < eff_size(2);
  endfunction

  function automatic int unsigned cell_addr(int x, int y, int z);
    return x + DefMaxX * (y + DefMaxY * z);
  endfunction

  // applies one transaction to the grid model; a query queues its expected jacobian
  task automatic predict_jacobian(req_t r);
    rsp_t e;
    int unsigned a, hi, lo, pos, n, stride, sh;
    logic signed [DerW-1:0] d [9];
    a = cell_addr(r.pos_x, r.pos_y, r.pos_z);
    if (r.cmd == CmdStore) begin
      if (inside_grid(r)) begin
        grid_mem[a][0] = r.comp_x;
        grid_mem[a][1] = r.comp_y;
        grid_mem[a][2] = r.comp_z;
        written[a] = 1'b1;
      end
      return;
    end
    e = '0;
    if (!inside_grid(r)) begin
      e.bad_index = 1'b1;
      jacobian_q.push_back(e);
      return;
    end
    for (int ax = 0; ax < 3; ax++) begin
      n = eff_size(ax);
      pos = (ax == 0) ? r.pos_x : (ax == 1) ? r.pos_y : r.pos_z;
      stride = (ax == 0) ? 1 : (ax == 1) ? DefMaxX : DefMaxX * DefMaxY;
      if (n <= 1) begin
        for (int c = 0; c < 3; c++) d[3*ax+c] = '0;
      end else begin
        if (pos == 0) begin
          hi = a + stride; lo = a; sh = 16;
        end else if (pos == n - 1) begin
          hi = a; lo = a - stride; sh = 16;
        end else begin
          hi = a + stride; lo = a - stride; sh = 17;
        end
        for (int c = 0; c < 3; c++)
          d[3*ax+c] = scale_diff(longint'(grid_mem[hi][c]) - longint'(grid_mem[lo][c]),
                                 inv_reg[ax], sh);
      end
    end
    e.dx_vx = d[0]; e.dx_vy = d[1]; e.dx_vz = d[2];
    e.dy_vx = d[3]; e.dy_vy = d[4]; e.dy_vz = d[5];
    e.dz_vx = d[6]; e.dz_vy = d[7]; e.dz_vz = d[8];
    jacobian_q.push_back(e);
  endtask

  // a query is safe only when the point and its used neighbours were stored; out-of-grid queries are safe
  function automatic bit query_safe(req_t r);
    int unsigned a, n, pos, stride;
    if (!inside_grid(r)) return 1'b1;
    a = cell_addr(r.pos_x, r.pos_y, r.pos_z);
    if (!written[a]) return 1'b0;
    for (int ax = 0; ax < 3; ax++) begin
      n = eff_size(ax);
      pos = (ax == 0) ? r.pos_x : (ax == 1) ? r.pos_y : r.pos_z;
      stride = (ax == 0) ? 1 : (ax == 1) ? DefMaxX : DefMaxX * DefMaxY;
      if (n > 1) begin
        if (pos < n - 1 && !written[a + stride]) return 1'b0;
        if (pos > 0 && !written[a - stride]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegSizeX: sz_reg[0] = val[SizeW-1:0];
      RegSizeY: sz_reg[1] = val[SizeW-1:0];
      RegSizeZ: sz_reg[2] = val[SizeW-1:0];
      RegSpaceX: inv_reg[0] = val;
      RegSpaceY: inv_reg[1] = val;
      RegSpaceZ: inv_reg[2] = val;
      default: ;
    endcase
  endtask

  // called at a falling edge; returns at a falling edge after acceptance, valid
  // left to the next call or to drain
  task automatic send_item(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    predict_jacobian(r);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (jacobian_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic req_t store_item(int x, int y, int z);
    req_t r;
    r.cmd = CmdStore;
    r.pos_x = PosW'(x); r.pos_y = PosW'(y); r.pos_z = PosW'(z);
    r.comp_x = CompW'($urandom); r.comp_y = CompW'($urandom); r.comp_z = CompW'($urandom);
    return r;
  endfunction

  function automatic req_t query_item(int x, int y, int z);
    req_t r;
    r = '0;
    r.cmd = CmdQuery;
    r.pos_x = PosW'(x); r.pos_y = PosW'(y); r.pos_z = PosW'(z);
    r.comp_x = CompW'($urandom); r.comp_y = CompW'($urandom); r.comp_z = CompW'($urandom);
    return r;
  endfunction

  task automatic set_grid(int sx, int sy, int sz, logic [31:0] ix, logic [31:0] iy,
                          logic [31:0] iz);
    drain();
    write_reg(RegSizeX, sx); write_reg(RegSizeY, sy); write_reg(RegSizeZ, sz);
    write_reg(RegSpaceX, ix); write_reg(RegSpaceY, iy); write_reg(RegSpaceZ, iz);
  endtask

  task automatic test_directed();
    req_t r;
    // small 3x3x3 block with extreme components, then queries inside and outside it
    set_grid(3, 3, 3, 32'h0001_0000, 32'hffff_ffff, 32'h0000_0000);
    write_reg(3'd7, 32'hdead_beef);  // unknown index, ignored
    for (int z = 0; z < 3; z++)
      for (int y = 0; y < 3; y++)
        for (int x = 0; x < 3; x++) begin
          r = store_item(x, y, z);
          if ((x + y + z) % 2 == 0) begin
            r.comp_x = 24'sh7fffff; r.comp_y = 24'sh800000; r.comp_z = '1;
          end else begin
            r.comp_x = 24'sh800000; r.comp_y = 24'sh7fffff; r.comp_z = '0;
          end
          send_item(r);
        end
    send_item(store_item(15, 15, 15));  // outside, ignored
    send_item(query_item(0, 0, 0));
    send_item(query_item(1, 1, 0));
    send_item(query_item(2, 2, 1));
    send_item(query_item(3, 0, 0));     // bad index
    send_item(query_item(15, 15, 15));
  endtask

  task automatic test_sizes();
    // size zero acts as one, size above maximum acts as maximum
    set_grid(0, 31, 1, 32'hffff_ffff, 32'h0000_8000, 32'h0001_0000);
    for (int y = 0; y < 16; y++) send_item(store_item(0, y, 0));
    send_item(query_item(0, 0, 0));
    send_item(query_item(0, 7, 0));
    send_item(query_item(0, 15, 0));
    send_item(query_item(1, 3, 0));
  endtask

  task automatic random_phase(int n_items, int sx, int sy, int sz);
    req_t r;
    int x, y, z, sent;
    sent = 0;
    while (sent < n_items) begin
      x = $urandom_range(sx - 1); y = $urandom_range(sy - 1); z = $urandom_range(sz - 1);
      if ($urandom_range(9) == 0) begin
        x = $urandom_range(15); y = $urandom_range(15); z = $urandom_range(15);
      end
      if ($urandom_range(1)) r = store_item(x, y, z);
      else r = query_item(x, y, z);
      if (r.cmd == CmdQuery && !query_safe(r)) r.cmd = CmdStore;
      if (r.cmd == CmdStore && !inside_grid(r) && $urandom_range(3) != 0) continue;
      send_item(r);
      sent++;
    end
  endtask

  task automatic test_random();
    int sx, sy, sz;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 19; recv_idle_pct = 58;
      end else if (ph < 4) begin
        send_idle_pct = 58; recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      sx = $urandom_range(1, 6); sy = $urandom_range(1, 6); sz = $urandom_range(1, 6);
      if (ph == 5) begin
        sx = 16; sy = 16; sz = 2;
      end
      set_grid(sx, sy, sz, $urandom, (ph == 1) ? 32'h0 : $urandom_range(1 << 20),
               (ph == 2) ? 32'hffff_ffff : $urandom_range(1 << 17));
      // store into the used region first (all of it when small) so queries are well formed
      for (int z = 0; z < sz; z++)
        for (int y = 0; y < sy; y++)
          for (int x = 0; x < sx; x++)
            if (sx * sy * sz <= 40 || $urandom_range(3) == 0) send_item(store_item(x, y, z));
      random_phase(250, sx, sy, sz);
    end
  endtask

  task automatic test_backpressure();
    set_grid(2, 2, 2, 32'h0001_0000, 32'h0002_0000, 32'h0000_4000);
    for (int i = 0; i < 8; i++) send_item(store_item(i % 2, (i / 2) % 2, i / 4));
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_item(query_item(i % 2, (i / 2) % 2, (i / 4) % 2));
    join
  endtask

  // receiver ready, randomly withheld
  always @(negedge clk_i) begin
    if (!rst_ni) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    rsp_t got, want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (jacobian_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        err_cnt++;
      end else begin
        want = jacobian_q.pop_front();
        if (got !== want) begin
          $display("%0t: jacobian mismatch expected %h actual %h", $time, want, got);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    sz_reg = '{5'd16, 5'd16, 5'd16};
    inv_reg = '{32'h10000, 32'h10000, 32'h10000};
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_sizes();
    test_backpressure();
    test_random();
    drain();
    if (err_cnt == 0 && jacobian_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
